### sv/assert_macros.svh
// Assertion macros shared by the keypad scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define KS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define KS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/kslp_pkg.sv
// Constants, register indexes and key table for the keypad scanner.
package kslp_pkg;

	localparam int ROW_W      = 4;
	localparam int COL_W      = 2;
	localparam int CODE_W     = 8;
	localparam int PRESS_W    = 16;
	localparam int HOLDOFF_W  = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF    = 2'd1;

	localparam logic [PRESS_W-1:0]   LONG_PRESS_RST = 16'd300;
	localparam logic [HOLDOFF_W-1:0] HOLDOFF_RST    = 8'd10;
	localparam logic [PRESS_W-1:0]   PRESS_MAX      = 16'hFFFF;

	localparam logic [CODE_W-1:0] CHAR_A    = 8'h41;
	localparam logic [CODE_W-1:0] CHAR_C    = 8'h43;
	localparam logic [CODE_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CODE_W-1:0] CHAR_D    = 8'h44;
	localparam logic [CODE_W-1:0] CHAR_NONE = 8'h00;

	// Character at (column, row) of the keypad face.
	function automatic logic [CODE_W-1:0] key_lut(input logic [COL_W-1:0] col,
			input logic [COL_W-1:0] row);
		logic [CODE_W-1:0] c;
		case ({col, row})
			4'h0: c = 8'h37; // '7'
			4'h1: c = 8'h34; // '4'
			4'h2: c = 8'h31; // '1'
			4'h3: c = 8'h41; // 'A'
			4'h4: c = 8'h38; // '8'
			4'h5: c = 8'h35; // '5'
			4'h6: c = 8'h32; // '2'
			4'h7: c = 8'h30; // '0'
			4'h8: c = 8'h39; // '9'
			4'h9: c = 8'h36; // '6'
			4'hA: c = 8'h33; // '3'
			4'hB: c = 8'h3D; // '='
			4'hC: c = 8'h2F; // '/'
			4'hD: c = 8'h78; // 'x'
			4'hE: c = 8'h2D; // '-'
			4'hF: c = 8'h2B; // '+'
			default: c = CHAR_NONE;
		endcase
		return c;
	endfunction

endpackage

### sv/keypad_scan_long_press.sv
// Keypad scanner top level: column scan, press timing and key remapping.
// A result beat is loaded into the output register in the cycle after its tick beat is accepted.
// Throughput: one tick beat per cycle; the output register stalls input only when full
// and out_ready is low.
// Reset (arst_n low): column 0, scanning, timers clear, thresholds 300 and 10 ticks.
// Thresholds are written through the cfg channel, which is always ready.
`include "assert_macros.svh"

module keypad_scan_long_press (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [kslp_pkg::ROW_W-1:0]        row_levels,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [kslp_pkg::ROW_W-1:0]        column_drive,
	output logic                              key_valid,
	output logic [kslp_pkg::CODE_W-1:0]       key_code,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [kslp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [kslp_pkg::CFG_DATA_W-1:0]   cfg_data
);

	typedef enum logic [1:0] {
		PH_SCAN = 2'd0,
		PH_HELD = 2'd1,
		PH_HOLD = 2'd2
	} phase_t;

	phase_t                              phase_q, phase_n;
	logic [kslp_pkg::COL_W-1:0]          col_q, col_n;
	logic [kslp_pkg::COL_W-1:0]          held_row_q, held_row_n;
	logic [kslp_pkg::PRESS_W-1:0]        press_q, press_n;
	logic [kslp_pkg::HOLDOFF_W-1:0]      holdoff_q, holdoff_n, holdoff_dec;
	logic [kslp_pkg::PRESS_W-1:0]        long_press_q;
	logic [kslp_pkg::HOLDOFF_W-1:0]      rel_holdoff_q;

	logic                                out_valid_q;
	logic [kslp_pkg::ROW_W-1:0]          col_drive_q;
	logic                                key_valid_q;
	logic [kslp_pkg::CODE_W-1:0]         key_code_q;

	logic                                in_fire;
	logic                                found;
	logic [kslp_pkg::COL_W-1:0]          low_row;
	logic [kslp_pkg::ROW_W-1:0]          drive;
	logic                                valid_n;
	logic [kslp_pkg::CODE_W-1:0]         code_raw, code_n;

	assign in_ready     = !out_valid_q || out_ready;
	assign in_fire      = in_valid && in_ready;
	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign column_drive = col_drive_q;
	assign key_valid    = key_valid_q;
	assign key_code     = key_code_q;

	assign drive       = ~(kslp_pkg::ROW_W'(1) << col_q);
	assign code_raw    = kslp_pkg::key_lut(col_q, held_row_q);
	assign holdoff_dec = (holdoff_q != '0) ? holdoff_q - 1'b1 : holdoff_q;

	// Lowest pressed row, active low.
	always_comb begin
		found   = 1'b1;
		low_row = '0;
		if (!row_levels[0]) begin
			low_row = 2'd0;
		end else if (!row_levels[1]) begin
			low_row = 2'd1;
		end else if (!row_levels[2]) begin
			low_row = 2'd2;
		end else if (!row_levels[3]) begin
			low_row = 2'd3;
		end else begin
			found = 1'b0;
		end
	end

	always_comb begin
		phase_n    = phase_q;
		col_n      = col_q;
		held_row_n = held_row_q;
		press_n    = press_q;
		holdoff_n  = holdoff_q;
		valid_n    = 1'b0;
		code_n     = kslp_pkg::CHAR_NONE;
		case (phase_q)
			PH_HELD: begin
				if (!row_levels[held_row_q]) begin
					if (press_q != kslp_pkg::PRESS_MAX) begin
						press_n = press_q + 1'b1;
					end
				end else begin
					valid_n = 1'b1;
					code_n  = code_raw;
					if (code_raw == kslp_pkg::CHAR_A && press_q < long_press_q) begin
						code_n = kslp_pkg::CHAR_C;
					end else if (code_raw == kslp_pkg::CHAR_ZERO && press_q > long_press_q) begin
						code_n = kslp_pkg::CHAR_D;
					end
					if (rel_holdoff_q == '0) begin
						col_n   = col_q + 1'b1;
						phase_n = PH_SCAN;
					end else begin
						holdoff_n = rel_holdoff_q;
						phase_n   = PH_HOLD;
					end
				end
			end
			PH_HOLD: begin
				holdoff_n = holdoff_dec;
				if (holdoff_dec == '0) begin
					col_n   = col_q + 1'b1;
					phase_n = PH_SCAN;
				end
			end
			default: begin
				// Unused phase code scans as well.
				if (found) begin
					held_row_n = low_row;
					press_n    = '0;
					phase_n    = PH_HELD;
				end else begin
					col_n   = col_q + 1'b1;
					phase_n = PH_SCAN;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_SCAN;
			col_q         <= '0;
			held_row_q    <= '0;
			press_q       <= '0;
			holdoff_q     <= '0;
			long_press_q  <= kslp_pkg::LONG_PRESS_RST;
			rel_holdoff_q <= kslp_pkg::HOLDOFF_RST;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					kslp_pkg::CFG_LONG_PRESS: long_press_q <= cfg_data;
					kslp_pkg::CFG_HOLDOFF:    rel_holdoff_q <= cfg_data[kslp_pkg::HOLDOFF_W-1:0];
					default: ;
				endcase
			end
			if (in_fire) begin
				phase_q    <= phase_n;
				col_q      <= col_n;
				held_row_q <= held_row_n;
				press_q    <= press_n;
				holdoff_q  <= holdoff_n;
			end
			// Hold the result beat until taken; load the next one on accept.
			if (in_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			col_drive_q <= drive;
			key_valid_q <= valid_n;
			key_code_q  <= code_n;
		end
	end

	`KS_ASSERT(a_idle_code_zero,
		(out_valid_q && !key_valid_q) |-> (key_code_q == kslp_pkg::CHAR_NONE),
		"no-key beat carries a nonzero code")
	`KS_ASSERT(a_one_column,
		out_valid_q |-> ($countones(~col_drive_q) == 1),
		"column drive must select exactly one column")
	`KS_ASSERT(a_holdoff_live,
		(phase_q == PH_HOLD) |-> (holdoff_q != '0),
		"holdoff phase with expired counter")
	`KS_ASSERT(a_release_emits,
		(in_fire && phase_q == PH_HELD && row_levels[held_row_q]) |=> (out_valid_q && key_valid_q),
		"release did not emit a key")
	`KS_ASSERT_ALWAYS(a_ready_when_empty,
		!out_valid_q |-> in_ready,
		"input stalled with empty output register")

endmodule
